FILE: rtl/core/ptp_pkg.sv
// ----------------------------------------------------------------------------
// ptp_pkg: shared types and defaults of the priority table
// Operation codes and the default sizes of the table.
// ----------------------------------------------------------------------------
package ptp_pkg;

  localparam int DEF_SLOTS         = 16;
  localparam int DEF_VALUE_BITS    = 32;
  localparam int DEF_PRIORITY_BITS = 16;
  localparam int QUEUE_DEPTH       = 4;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_PROMOTE = 2'd1,
    KIND_LOOKUP  = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

endpackage

FILE: rtl/core/ptp_front.sv
// ----------------------------------------------------------------------------
// ptp_front: input stage of the priority table
// Accepts words, decodes the operation kind, drops unused payload and
// hands the operation to the queue.
// ----------------------------------------------------------------------------
module ptp_front
  import ptp_pkg::*;
#(
  parameter int ID_BITS    = 4,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int QW         = 2 + ID_BITS + VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [ID_BITS-1:0]    in_id,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [QW-1:0]         push_data
);

  logic                  hold_valid_r;
  kind_t                 kind_r;
  logic [ID_BITS-1:0]    id_r;
  logic [VALUE_BITS-1:0] value_r;
  kind_t                 kind_dec;

  // every 2-bit code is a defined kind
  assign kind_dec = kind_t'(in_kind);

  assign in_ready   = !hold_valid_r || push_ready;
  assign push_valid = hold_valid_r;
  assign push_data  = {value_r, id_r, kind_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= kind_dec;
      id_r    <= in_id;
      // only an add carries a payload
      value_r <= (kind_dec == KIND_ADD) ? in_value : '0;
    end
  end

endmodule

FILE: rtl/core/ptp_fifo.sv
// ----------------------------------------------------------------------------
// ptp_fifo: operation queue
// Small register queue between the input stage and the execution stage.
// ----------------------------------------------------------------------------
module ptp_fifo
  import ptp_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push_fire, pop_fire;

  assign push_ready = count_r != CW'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/ptp_back.sv
// ----------------------------------------------------------------------------
// ptp_back: execution stage of the priority table
// Reads the slot, applies add, promote or lookup, tracks the best entry
// and holds the result word until the receiver takes it.
// ----------------------------------------------------------------------------
module ptp_back
  import ptp_pkg::*;
#(
  parameter int SLOTS         = DEF_SLOTS,
  parameter int ID_BITS       = 4,
  parameter int VALUE_BITS    = DEF_VALUE_BITS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
  parameter int QW            = 2 + ID_BITS + VALUE_BITS,
  parameter int OW            = 2 * (ID_BITS + VALUE_BITS + PRIORITY_BITS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  logic [QW-1:0] pop_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [OW-1:0] out_data
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = ID_BITS;
  localparam int VW = VALUE_BITS;
  localparam int PB = PRIORITY_BITS;

  typedef enum logic [0:0] {
    B_IDLE,
    B_EXEC
  } bstate_t;

  bstate_t       state_r;
  kind_t         op_kind_r;
  logic [IW-1:0] op_id_r;
  logic [VW-1:0] op_val_r;

  logic [VW-1:0] mem_val [SLOTS];
  logic [PB-1:0] mem_pri [SLOTS];
  logic [VW-1:0] rd_val_r;
  logic [PB-1:0] rd_pri_r;

  logic [CW-1:0] used_r, used_nxt;
  logic [IW-1:0] best_slot_r, best_slot_nxt;
  logic [PB-1:0] best_pri_r, best_pri_nxt;
  logic [VW-1:0] best_val_r, best_val_nxt;
  logic          out_valid_r;
  logic [OW-1:0] out_data_r, out_data_nxt;

  logic          pop_fire, exec_fire, out_free;
  logic          stored, full;
  logic [PB-1:0] pri_inc;
  logic          wr_val_en, wr_pri_en;
  logic [IW-1:0] wr_addr;
  logic [PB-1:0] wr_pri;
  logic [IW-1:0] new_id;
  logic          ok;
  logic [VW-1:0] e_val;
  logic [PB-1:0] e_pri;
  logic          present;

  assign pop_ready = state_r == B_IDLE;
  assign pop_fire  = pop_valid && pop_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign exec_fire = (state_r == B_EXEC) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stored  = CW'(op_id_r) < used_r;
  assign full    = used_r == CW'(SLOTS);
  assign pri_inc = rd_pri_r + 1'b1;

  always_comb begin
    used_nxt      = used_r;
    best_slot_nxt = best_slot_r;
    best_pri_nxt  = best_pri_r;
    best_val_nxt  = best_val_r;
    wr_val_en     = 1'b0;
    wr_pri_en     = 1'b0;
    wr_addr       = op_id_r;
    wr_pri        = '0;
    new_id        = '0;
    ok            = 1'b0;
    e_val         = '0;
    e_pri         = '0;
    case (op_kind_r)
      KIND_ADD: begin
        if (!full) begin
          wr_val_en = 1'b1;
          wr_pri_en = 1'b1;
          wr_addr   = used_r[IW-1:0];
          wr_pri    = '0;
          if (used_r == '0 || best_pri_r == '0) begin
            best_slot_nxt = used_r[IW-1:0];
            best_pri_nxt  = '0;
            best_val_nxt  = op_val_r;
          end
          used_nxt = used_r + 1'b1;
          new_id   = used_r[IW-1:0];
          ok       = 1'b1;
        end
      end
      KIND_PROMOTE: begin
        if (stored) begin
          ok    = 1'b1;
          e_val = rd_val_r;
          e_pri = rd_pri_r;
          // saturate: at the top level nothing changes
          if (rd_pri_r != '1) begin
            wr_pri_en = 1'b1;
            wr_pri    = pri_inc;
            e_pri     = pri_inc;
            if (pri_inc >= best_pri_r) begin
              best_slot_nxt = op_id_r;
              best_pri_nxt  = pri_inc;
              best_val_nxt  = rd_val_r;
            end
          end
        end
      end
      KIND_LOOKUP: begin
        if (stored) begin
          ok    = 1'b1;
          e_val = rd_val_r;
          e_pri = rd_pri_r;
        end
      end
      default: begin
      end
    endcase
    present = used_nxt != '0;
    out_data_nxt = {present ? best_pri_nxt : {PB{1'b0}},
                    present ? best_val_nxt : {VW{1'b0}},
                    present ? best_slot_nxt : {IW{1'b0}},
                    present, e_pri, e_val, ok, new_id};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      used_r      <= '0;
      best_slot_r <= '0;
      best_pri_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            state_r <= B_EXEC;
          end
        end
        B_EXEC: begin
          if (out_free) begin
            state_r     <= B_IDLE;
            used_r      <= used_nxt;
            best_slot_r <= best_slot_nxt;
            best_pri_r  <= best_pri_nxt;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      op_kind_r <= kind_t'(pop_data[1:0]);
      op_id_r   <= pop_data[IW+1:2];
      op_val_r  <= pop_data[QW-1:IW+2];
    end
    if (exec_fire) begin
      best_val_r <= best_val_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  // slot memory: read on dequeue, write back on execute
  always_ff @(posedge clk) begin
    if (pop_fire) begin
      rd_val_r <= mem_val[pop_data[IW+1:2]];
      rd_pri_r <= mem_pri[pop_data[IW+1:2]];
    end
    if (exec_fire && wr_val_en) begin
      mem_val[wr_addr] <= op_val_r;
    end
    if (exec_fire && wr_pri_en) begin
      mem_pri[wr_addr] <= wr_pri;
    end
  end

endmodule

FILE: rtl/core/priority_table_with_promote_core.sv
// ----------------------------------------------------------------------------
// priority_table_with_promote_core: slot table with promote and max tracking
// Add stores a value at priority 0 in the next free slot, promote raises
// an entry's priority by one with saturation, lookup reads an entry.
// Every operation returns one result word that also reports the entry of
// highest priority (a tie goes to the entry that reached that level last).
//
// Input channel: in_tuser carries the kind (0 add, 1 promote, 2 lookup,
// 3 no operation); in_tdata carries the slot id and the value to add.
// An input register feeds a four-entry queue, so words are taken while
// execution or the output is busy.
// The execution stage handles one word at a time: it reads the slot
// memory, then updates it and loads the output register, and takes the
// next word from the queue only after that. A word passes the input
// register, the queue, the slot read and then the output register.
// Reset empties the table and the queue; slot contents stay undefined
// until written. When out_tready is low the result is held, execution
// stops and the queue then the input stage fill before in_tready drops.
// ----------------------------------------------------------------------------
module priority_table_with_promote_core
  import ptp_pkg::*;
#(
  parameter int SLOTS         = DEF_SLOTS,
  parameter int VALUE_BITS    = DEF_VALUE_BITS,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
  localparam int ID_BITS      = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int IN_BITS      = ID_BITS + VALUE_BITS,
  localparam int IN_W         = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS     = 2 * (ID_BITS + VALUE_BITS + PRIORITY_BITS + 1),
  localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // fields from bit 0: entry_id, item_value
  input  logic [IN_W-1:0]  in_tdata,
  // fields from bit 0: kind
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // fields from bit 0: new_id, ok, entry_value, entry_priority,
  // max_present, max_id, max_value, max_priority
  output logic [OUT_W-1:0] out_tdata
);

  localparam int QW = 2 + ID_BITS + VALUE_BITS;

  logic            push_valid, push_ready;
  logic [QW-1:0]   push_data;
  logic            pop_valid, pop_ready;
  logic [QW-1:0]   pop_data;
  logic [OUT_BITS-1:0] res_data;

  ptp_front #(
    .ID_BITS    (ID_BITS),
    .VALUE_BITS (VALUE_BITS),
    .QW         (QW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_id      (in_tdata[ID_BITS-1:0]),
    .in_value   (in_tdata[IN_BITS-1:ID_BITS]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ptp_fifo #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ptp_back #(
    .SLOTS         (SLOTS),
    .ID_BITS       (ID_BITS),
    .VALUE_BITS    (VALUE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .QW            (QW),
    .OW            (OUT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_data)
  );

  assign out_tdata = OUT_W'(res_data);

endmodule
